// ===== rtl/string_hash_set_linear_probe_defines.svh =====
// Assertion macros for the string hash set block.
`ifndef STRING_HASH_SET_LINEAR_PROBE_DEFINES_SVH
`define STRING_HASH_SET_LINEAR_PROBE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SHSLP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SHSLP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/shslp_pkg.sv =====
// Package for the string hash set: codes, state type and the crypt table.
package shslp_pkg;

  localparam int CHECK_W     = 32;
  localparam int SLOT_W      = 10;
  localparam int CRYPT_WORDS = 1280;

  localparam logic [31:0] SEED1_START = 32'h7FED7FED;
  localparam logic [31:0] SEED2_START = 32'hEEEEEEEE;
  localparam logic [31:0] LCG_START   = 32'h00100001;
  localparam logic [31:0] LCG_MUL     = 32'd125;
  localparam logic [31:0] LCG_INC     = 32'd3;
  localparam logic [31:0] LCG_MOD     = 32'h002AAAAB;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_CLEAR  = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    OUT_NOT_FOUND = 3'd0,
    OUT_FOUND     = 3'd1,
    OUT_INSERTED  = 3'd2,
    OUT_PRESENT   = 3'd3,
    OUT_FULL      = 3'd4,
    OUT_CLEARED   = 3'd5
  } outcome_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_CHECK
  } state_e;

  typedef logic [CRYPT_WORDS-1:0][31:0] crypt_rom_t;

  // Builds the crypt table from its generator; evaluated at elaboration only.
  function automatic crypt_rom_t build_crypt_rom();
    crypt_rom_t  rom;
    logic [31:0] s;
    s   = LCG_START;
    rom = '0;
    for (int row = 0; row < 256; row++) begin
      for (int k = 0; k < 5; k++) begin
        s = (s * LCG_MUL + LCG_INC) % LCG_MOD;
        rom[k * 256 + row][31:16] = s[15:0];
        s = (s * LCG_MUL + LCG_INC) % LCG_MOD;
        rom[k * 256 + row][15:0] = s[15:0];
      end
    end
    return rom;
  endfunction

  localparam crypt_rom_t CRYPT_ROM = build_crypt_rom();

endpackage

// ===== rtl/shslp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module shslp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/string_hash_set_linear_probe.sv =====
// String hash set with one-way MPQ-style hashing and linear probing.
//
// Usage: drive opcode_i, key_byte_i and last_byte_i with start high; an item
// is taken at a rising edge where start is high and busy is low. Lookup and
// insert bytes fold into three hash seed pairs, so a key streams at one
// byte per cycle. The last byte of a key starts the probe: the type-0 hash
// is reduced modulo TABLE_SIZE by a reciprocal multiply, a remainder step
// and a final correction, then the slot memory is read once and probed at
// one slot per cycle, since each probe waits on the registered read of the
// slot RAM. The result appears on outcome_o and slot_index_o for exactly
// one cycle with done_o high, in the cycle after the probe ends. A clear
// item sweeps the slot RAM one entry per cycle and then reports outcome
// "cleared". After reset the same sweep runs without a result, and busy
// stays high throughout it. The receiver cannot stall: every result must
// be taken in the cycle it is shown.
module string_hash_set_linear_probe
  import shslp_pkg::*;
#(
  parameter int TABLE_SIZE = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        opcode_i,
  input  logic [7:0]        key_byte_i,
  input  logic              last_byte_i,
  output logic              done_o,
  output logic [2:0]        outcome_o,
  output logic [SLOT_W-1:0] slot_index_o
);

  `include "string_hash_set_linear_probe_defines.svh"

  localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int MEM_W = 2 * CHECK_W + 1;
  localparam logic [31:0]      TS_W     = 32'(TABLE_SIZE);
  localparam logic [31:0]      RECIP    = 32'((64'd1 << 32) / 64'(TABLE_SIZE));
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

  state_e state_q, state_d;

  logic [31:0] seed1_q [3];
  logic [31:0] seed2_q [3];
  logic [31:0] seed1_d [3];
  logic [31:0] seed2_d [3];
  logic [31:0] seed1_n [3];
  logic [31:0] seed2_n [3];

  logic [IDX_W-1:0] pos_q, pos_d, home_q, home_d, pos_inc;
  logic [1:0]       cnt_q, cnt_d;
  logic             ins_q, ins_d;
  logic             report_q, report_d;
  logic [31:0]      dvd_q, dvd_d;
  logic [31:0]      qe_q, qe_d, red_q, red_d;
  logic [31:0]      ha_q, ha_d, hb_q, hb_d;

  logic             done_q, done_d;
  outcome_e         outcome_q, outcome_d;
  logic [SLOT_W-1:0] slot_q, slot_d;

  logic [7:0]       char_u;
  logic [63:0]      prod;
  logic [31:0]      qn, red_sub;
  logic [IDX_W-1:0] red_fix;
  logic [IDX_W+SLOT_W-1:0] pos_ext;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [MEM_W-1:0] ram_wdata, ram_rdata;
  logic             slot_valid;
  logic [31:0]      slot_a, slot_b;
  logic             accept;
  logic             key_end;
  logic             no_slot_done;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  // Case folding and the three seed updates for the incoming byte.
  always_comb begin
    char_u = key_byte_i;
    if (key_byte_i >= 8'h61 && key_byte_i <= 8'h7A) begin
      char_u = key_byte_i - 8'h20;
    end
    for (int t = 0; t < 3; t++) begin
      seed1_n[t] = CRYPT_ROM[{3'(t), char_u}] ^ (seed1_q[t] + seed2_q[t]);
      seed2_n[t] = {24'd0, char_u} + seed1_n[t] + seed2_q[t]
                   + {seed2_q[t][26:0], 5'd0} + 32'd3;
    end
  end

  // The quotient estimate is exact or one too small, so one subtraction
  // of TABLE_SIZE at most brings the remainder into range.
  assign prod    = 64'(dvd_q) * 64'(RECIP);
  assign qn      = qe_q * TS_W;
  assign red_sub = red_q - TS_W;
  assign red_fix = (red_q >= TS_W) ? red_sub[IDX_W-1:0] : red_q[IDX_W-1:0];

  assign pos_inc = (pos_q == LAST_IDX) ? '0 : pos_q + 1'b1;
  assign pos_ext = {{SLOT_W{1'b0}}, pos_q};

  assign slot_valid = ram_rdata[MEM_W-1];
  assign slot_a     = ram_rdata[2*CHECK_W-1:CHECK_W];
  assign slot_b     = ram_rdata[CHECK_W-1:0];

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    home_d    = home_q;
    cnt_d     = cnt_q;
    ins_d     = ins_q;
    report_d  = report_q;
    dvd_d     = dvd_q;
    qe_d      = qe_q;
    red_d     = red_q;
    ha_d      = ha_q;
    hb_d      = hb_q;
    done_d    = 1'b0;
    outcome_d = outcome_q;
    slot_d    = slot_q;
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = '0;
    ram_raddr = pos_q;
    for (int t = 0; t < 3; t++) begin
      seed1_d[t] = seed1_q[t];
      seed2_d[t] = seed2_q[t];
    end

    unique case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (pos_q == LAST_IDX) begin
          state_d = ST_IDLE;
          if (report_q) begin
            done_d    = 1'b1;
            outcome_d = OUT_CLEARED;
            slot_d    = '0;
          end
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (opcode_i)
            OP_LOOKUP, OP_INSERT: begin
              if (last_byte_i) begin
                dvd_d   = seed1_n[0];
                ha_d    = seed1_n[1];
                hb_d    = seed1_n[2];
                ins_d   = (opcode_i == OP_INSERT);
                cnt_d   = '0;
                state_d = ST_MOD;
                for (int t = 0; t < 3; t++) begin
                  seed1_d[t] = SEED1_START;
                  seed2_d[t] = SEED2_START;
                end
              end else begin
                for (int t = 0; t < 3; t++) begin
                  seed1_d[t] = seed1_n[t];
                  seed2_d[t] = seed2_n[t];
                end
              end
            end
            OP_CLEAR: begin
              pos_d    = '0;
              report_d = 1'b1;
              state_d  = ST_CLEAR;
              for (int t = 0; t < 3; t++) begin
                seed1_d[t] = SEED1_START;
                seed2_d[t] = SEED2_START;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_MOD: begin
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd0) begin
          qe_d = prod[63:32];
        end else if (cnt_q == 2'd1) begin
          red_d = dvd_q - qn;
        end else begin
          pos_d   = red_fix;
          home_d  = red_fix;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        // Read data belongs to pos_q; the next slot is addressed meanwhile.
        ram_raddr = pos_inc;
        if (!slot_valid) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
          if (ins_q) begin
            ram_we    = 1'b1;
            ram_wdata = {1'b1, ha_q, hb_q};
            outcome_d = OUT_INSERTED;
            slot_d    = pos_ext[SLOT_W-1:0];
          end else begin
            outcome_d = OUT_NOT_FOUND;
            slot_d    = '0;
          end
        end else if (slot_a == ha_q && slot_b == hb_q) begin
          done_d    = 1'b1;
          state_d   = ST_IDLE;
          outcome_d = ins_q ? OUT_PRESENT : OUT_FOUND;
          slot_d    = pos_ext[SLOT_W-1:0];
        end else if (pos_inc == home_q) begin
          done_d    = 1'b1;
          state_d   = ST_IDLE;
          outcome_d = ins_q ? OUT_FULL : OUT_NOT_FOUND;
          slot_d    = '0;
        end else begin
          pos_d = pos_inc;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      cnt_q    <= '0;
      report_q <= 1'b0;
      done_q   <= 1'b0;
      for (int t = 0; t < 3; t++) begin
        seed1_q[t] <= SEED1_START;
        seed2_q[t] <= SEED2_START;
      end
    end else begin
      pos_q    <= pos_d;
      cnt_q    <= cnt_d;
      report_q <= report_d;
      done_q   <= done_d;
      for (int t = 0; t < 3; t++) begin
        seed1_q[t] <= seed1_d[t];
        seed2_q[t] <= seed2_d[t];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    home_q    <= home_d;
    ins_q     <= ins_d;
    dvd_q     <= dvd_d;
    qe_q      <= qe_d;
    red_q     <= red_d;
    ha_q      <= ha_d;
    hb_q      <= hb_d;
    outcome_q <= outcome_d;
    slot_q    <= slot_d;
  end

  shslp_ram #(
    .WIDTH (MEM_W),
    .DEPTH (TABLE_SIZE)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign done_o       = done_q;
  assign outcome_o    = outcome_q;
  assign slot_index_o = slot_q;

  assign key_end      = accept && last_byte_i
                        && (opcode_i == OP_LOOKUP || opcode_i == OP_INSERT);
  assign no_slot_done = done_o && (outcome_o == OUT_FULL || outcome_o == OUT_CLEARED);

  `SHSLP_ASSERT_NEXT(a_done_single, done_o, !done_o, "result strobe lasted two cycles")
  `SHSLP_ASSERT_NEXT(a_last_busy, key_end, busy, "probe did not start after last byte")
  `SHSLP_ASSERT_NOW(a_write_ins, (state_q == ST_CHECK) && ram_we, ins_q, "write in a lookup")
  `SHSLP_ASSERT_NOW(a_no_slot, no_slot_done, slot_index_o == '0, "slot index without a slot")

endmodule

// ===== sim/hash_set_checker.sv =====
// Result checker for the string hash set: predicts each outcome and compares it.
`timescale 1ns / 100ps

module hash_set_checker
  import shslp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  logic [1:0]        opcode_i,
  input  logic [7:0]        key_byte_i,
  input  logic              last_byte_i,
  input  logic              done_o_i,
  input  logic [2:0]        outcome_i,
  input  logic [SLOT_W-1:0] slot_index_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                slots_used_o
);

  localparam int          TABLE_SLOTS = 1 << SLOT_W;
  localparam int          ROM_WORDS   = 1280;
  localparam logic [31:0] LCG_SEED    = 32'h0010_0001;
  localparam logic [31:0] LCG_MODULUS = 32'h002A_AAAB;
  localparam logic [31:0] SEED_A_INIT = 32'h7FED_7FED;
  localparam logic [31:0] SEED_B_INIT = 32'hEEEE_EEEE;
  localparam int          FIFO_DEPTH  = 4;

  typedef struct packed {
    outcome_e          outcome;
    logic [SLOT_W-1:0] slot;
  } probe_result_t;

  logic [31:0]   crypt_word [ROM_WORDS];
  logic [31:0]   key_seed   [6];
  logic [31:0]   tag_a      [TABLE_SLOTS];
  logic [31:0]   tag_b      [TABLE_SLOTS];
  logic          slot_used  [TABLE_SLOTS];
  probe_result_t pending_fifo [FIFO_DEPTH];
  logic [1:0]    rd_ptr;
  logic [1:0]    wr_ptr;
  int            pending_cnt;

  initial begin : build_crypt_words
    logic [31:0] lcg;
    lcg = LCG_SEED;
    for (int row = 0; row < 256; row++) begin
      for (int k = 0; k < 5; k++) begin
        lcg = (lcg * 32'd125 + 32'd3) % LCG_MODULUS;
        crypt_word[k * 256 + row][31:16] = lcg[15:0];
        lcg = (lcg * 32'd125 + 32'd3) % LCG_MODULUS;
        crypt_word[k * 256 + row][15:0] = lcg[15:0];
      end
    end
  end

  function automatic void restart_seeds();
    for (int t = 0; t < 3; t++) begin
      key_seed[2 * t]     = SEED_A_INIT;
      key_seed[2 * t + 1] = SEED_B_INIT;
    end
  endfunction

  function automatic void empty_table();
    foreach (slot_used[i]) slot_used[i] = 1'b0;
    slots_used_o = 0;
  endfunction

  // Appends one expected result; more than FIFO_DEPTH waiting means results went missing.
  function automatic void queue_result(input probe_result_t r);
    if (pending_cnt == FIFO_DEPTH) begin
      fail_count_o++;
      $display("%0t: too many results outstanding, expected at most %0d, actual %0d",
               $time, FIFO_DEPTH, pending_cnt + 1);
    end else begin
      pending_fifo[wr_ptr] = r;
      wr_ptr               = wr_ptr + 2'd1;
      pending_cnt++;
    end
  endfunction

  // Folds one key character into all three seed pairs; only ASCII a-z is upper-cased.
  function automatic void fold_key_byte(input logic [7:0] ch);
    logic [31:0] c;
    logic [31:0] s1;
    logic [31:0] s2;
    c = {24'd0, ch};
    if (ch >= 8'h61 && ch <= 8'h7A) c = c - 32'h20;
    for (int t = 0; t < 3; t++) begin
      s1 = key_seed[2 * t];
      s2 = key_seed[2 * t + 1];
      s1 = crypt_word[t * 256 + c] ^ (s1 + s2);
      s2 = c + s1 + s2 + (s2 << 5) + 32'd3;
      key_seed[2 * t]     = s1;
      key_seed[2 * t + 1] = s2;
    end
  endfunction

  // Walks the table from the home slot of the finished key and applies the lookup or insert.
  function automatic probe_result_t probe_slots(input logic [1:0] op);
    logic [SLOT_W-1:0] pos;
    logic [31:0]       want_a;
    logic [31:0]       want_b;
    probe_result_t     res;
    pos    = SLOT_W'(key_seed[0] % TABLE_SLOTS);
    want_a = key_seed[2];
    want_b = key_seed[4];
    restart_seeds();
    res.outcome = OUT_NOT_FOUND;
    res.slot    = '0;
    // The slot index is exactly SLOT_W bits wide, so the increment wraps on its own.
    for (int n = 0; n < TABLE_SLOTS; n++) begin
      if (!slot_used[pos]) begin
        if (op == OP_INSERT) begin
          tag_a[pos]     = want_a;
          tag_b[pos]     = want_b;
          slot_used[pos] = 1'b1;
          slots_used_o++;
          res.outcome = OUT_INSERTED;
          res.slot    = pos;
        end
        return res;
      end
      if (tag_a[pos] == want_a && tag_b[pos] == want_b) begin
        if (op == OP_INSERT) res.outcome = OUT_PRESENT;
        else res.outcome = OUT_FOUND;
        res.slot = pos;
        return res;
      end
      pos = pos + 1'b1;
    end
    if (op == OP_INSERT) res.outcome = OUT_FULL;
    return res;
  endfunction

  always @(posedge clk_i) begin
    probe_result_t want;
    probe_result_t cleared;
    if (!rst_ni) begin
      restart_seeds();
      empty_table();
      rd_ptr       = '0;
      wr_ptr       = '0;
      pending_cnt  = 0;
      fail_count_o = 0;
    end else begin
      // A result never belongs to the item taken at the same edge, so compare first.
      if (done_o_i) begin
        if (pending_cnt == 0) begin
          fail_count_o++;
          $display("%0t: unexpected result, expected none, actual outcome %0d slot %0d",
                   $time, outcome_i, slot_index_i);
        end else begin
          want   = pending_fifo[rd_ptr];
          rd_ptr = rd_ptr + 2'd1;
          pending_cnt--;
          if (outcome_i !== want.outcome) begin
            fail_count_o++;
            $display("%0t: outcome mismatch, expected %0d, actual %0d",
                     $time, want.outcome, outcome_i);
          end
          if (slot_index_i !== want.slot) begin
            fail_count_o++;
            $display("%0t: slot mismatch, expected %0d, actual %0d",
                     $time, want.slot, slot_index_i);
          end
        end
      end
      if (start_i && !busy_i) begin
        case (opcode_i)
          OP_CLEAR: begin
            empty_table();
            restart_seeds();
            cleared.outcome = OUT_CLEARED;
            cleared.slot    = '0;
            queue_result(cleared);
          end
          OP_LOOKUP, OP_INSERT: begin
            fold_key_byte(key_byte_i);
            if (last_byte_i) queue_result(probe_slots(opcode_i));
          end
          default: begin
            // The spare opcode is dropped without touching any state.
          end
        endcase
      end
    end
    pending_o = pending_cnt;
  end

endmodule

// ===== sim/tb_string_hash_set_linear_probe.sv =====
// Testbench top for the string hash set: drives key items and gives the verdict.
`timescale 1ns / 100ps

module tb_string_hash_set_linear_probe;
  import shslp_pkg::*;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         TABLE_SLOTS  = 1 << SLOT_W;
  localparam int         PHASE_A_END  = 100;
  localparam int         NO_GAP_FROM  = 300;
  localparam int         NO_GAP_TO    = 900;
  localparam int         STALL_LIMIT  = 6000;
  localparam int         DRAIN_CYCLES = 1100;
  localparam int         KEY_SLOTS    = 2048;

  typedef struct packed {
    logic [2:0]  len;
    logic [31:0] text;
  } key_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [1:0]        opcode_i;
  logic [7:0]        key_byte_i;
  logic              last_byte_i;
  logic              done_o;
  logic [2:0]        outcome_o;
  logic [SLOT_W-1:0] slot_index_o;
  int                fail_count;
  int                pending_results;
  int                slots_used;
  int                items_sent;
  key_t              known_keys [KEY_SLOTS];
  int                key_count;

  string_hash_set_linear_probe dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .opcode_i     (opcode_i),
    .key_byte_i   (key_byte_i),
    .last_byte_i  (last_byte_i),
    .done_o       (done_o),
    .outcome_o    (outcome_o),
    .slot_index_o (slot_index_o)
  );

  hash_set_checker outcome_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .opcode_i     (opcode_i),
    .key_byte_i   (key_byte_i),
    .last_byte_i  (last_byte_i),
    .done_o_i     (done_o),
    .outcome_i    (outcome_o),
    .slot_index_i (slot_index_o),
    .fail_count_o (fail_count),
    .pending_o    (pending_results),
    .slots_used_o (slots_used)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Starts and ends on a falling edge; start stays high so back-to-back items need no toggle.
  task automatic send_item(input logic [1:0] op, input logic [7:0] ch, input logic last);
    int gap;
    gap = 0;
    if (items_sent < NO_GAP_FROM || items_sent >= NO_GAP_TO)
      while ($urandom_range(99) < 16) gap++;
    if (gap > 0) begin
      start       = 1'b0;
      opcode_i    = 2'($urandom);
      key_byte_i  = 8'($urandom);
      last_byte_i = 1'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    start       = 1'b1;
    opcode_i    = op;
    key_byte_i  = ch;
    last_byte_i = last;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_key(input logic [1:0] op, input key_t k);
    for (int i = 0; i < k.len; i++) send_item(op, k.text[8 * i +: 8], i == k.len - 1);
  endtask

  // Only the opcode on the last byte should decide lookup or insert.
  task automatic send_mixed_key(input logic [1:0] op, input key_t k);
    for (int i = 0; i < k.len; i++) begin
      if (i == k.len - 1) send_item(op, k.text[8 * i +: 8], 1'b1);
      else send_item($urandom_range(1) ? OP_INSERT : OP_LOOKUP, k.text[8 * i +: 8], 1'b0);
    end
  endtask

  function automatic key_t random_key(input int min_len, input int max_len);
    key_t k;
    k.len  = 3'($urandom_range(min_len, max_len));
    k.text = $urandom;
    return k;
  endfunction

  function automatic void remember_key(input key_t k);
    if (key_count < KEY_SLOTS) begin
      known_keys[key_count] = k;
      key_count++;
    end
  endfunction

  function automatic key_t any_known_key();
    return known_keys[$urandom_range(key_count - 1)];
  endfunction

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((start && !busy) || done_o) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    key_t       k;
    int         pick;
    int         j;
    logic [1:0] op;
    logic [7:0] tmp;
    logic [7:0] single_bytes [256];

    start       = 1'b0;
    opcode_i    = OP_LOOKUP;
    key_byte_i  = 8'd0;
    last_byte_i = 1'b0;
    items_sent  = 0;
    key_count   = 0;
    rst_ni      = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Case folding, extreme bytes, repeat insert and bytes above 127.
    send_key(OP_INSERT, key_t'{3'd1, 32'h0000_0061});
    send_key(OP_LOOKUP, key_t'{3'd1, 32'h0000_0041});
    send_key(OP_INSERT, key_t'{3'd2, 32'h0000_00FF});
    send_key(OP_LOOKUP, key_t'{3'd2, 32'h0000_00FF});
    send_key(OP_INSERT, key_t'{3'd2, 32'h0000_00FF});
    send_key(OP_INSERT, key_t'{3'd1, 32'h0000_00E1});
    send_key(OP_LOOKUP, key_t'{3'd1, 32'h0000_00C1});
    // Mixed opcodes inside one key.
    send_item(OP_INSERT, 8'h7A, 1'b0);
    send_item(OP_LOOKUP, 8'h5A, 1'b1);
    send_item(OP_LOOKUP, 8'h7A, 1'b0);
    send_item(OP_INSERT, 8'h5A, 1'b1);
    send_key(OP_LOOKUP, key_t'{3'd2, 32'h0000_5A5A});
    // The spare opcode in the middle of a key must not disturb it.
    send_item(OP_INSERT, 8'h31, 1'b0);
    send_item(OP_UNUSED, 8'hFF, 1'b1);
    send_item(OP_INSERT, 8'h32, 1'b1);
    send_key(OP_LOOKUP, key_t'{3'd2, 32'h0000_3231});
    // A clear drops the partial key as well as the table.
    send_item(OP_LOOKUP, 8'h41, 1'b0);
    send_item(OP_CLEAR, 8'hFF, 1'b1);
    send_key(OP_LOOKUP, key_t'{3'd1, 32'h0000_0041});
    send_item(OP_UNUSED, 8'h00, 1'b0);

    // Mostly well-formed keys against a lightly loaded table, with some broken sequences.
    while (items_sent < PHASE_A_END) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        k = random_key(1, 4);
        send_key(OP_INSERT, k);
        remember_key(k);
      end else if (pick < 65 && key_count > 0) begin
        send_key(OP_LOOKUP, any_known_key());
      end else if (pick < 75) begin
        send_key(OP_LOOKUP, random_key(1, 4));
      end else if (pick < 83 && key_count > 0) begin
        send_key(OP_INSERT, any_known_key());
      end else if (pick < 90) begin
        k  = random_key(1, 4);
        op = $urandom_range(1) ? OP_INSERT : OP_LOOKUP;
        send_mixed_key(op, k);
        if (op == OP_INSERT) remember_key(k);
      end else if (pick < 93) begin
        send_item(OP_UNUSED, 8'($urandom), 1'($urandom));
      end else if (pick < 96) begin
        k = random_key(2, 4);
        for (int i = 0; i < k.len - 1; i++)
          send_item($urandom_range(1) ? OP_INSERT : OP_LOOKUP, k.text[8 * i +: 8], 1'b0);
        send_item(OP_CLEAR, 8'($urandom), 1'($urandom));
        key_count = 0;
      end else if (pick < 98) begin
        send_item(OP_CLEAR, 8'($urandom), 1'($urandom));
        key_count = 0;
      end else begin
        k = random_key(1, 3);
        send_item(OP_INSERT, 8'($urandom), 1'b0);
        send_item(OP_UNUSED, 8'($urandom), 1'($urandom));
        send_key(OP_INSERT, k);
      end
    end

    // Fill the table: every single-byte key in shuffled order, then random two-byte keys.
    send_item(OP_CLEAR, 8'($urandom), 1'($urandom));
    key_count = 0;
    for (int i = 0; i < 256; i++) single_bytes[i] = 8'(i);
    for (int i = 255; i > 0; i--) begin
      j               = $urandom_range(i);
      tmp             = single_bytes[i];
      single_bytes[i] = single_bytes[j];
      single_bytes[j] = tmp;
    end
    for (int i = 0; i < 256; i++) begin
      k = key_t'{3'd1, {24'd0, single_bytes[i]}};
      send_key(OP_INSERT, k);
      remember_key(k);
    end
    while (slots_used < TABLE_SLOTS) begin
      if ($urandom_range(99) < 5) begin
        send_key(OP_LOOKUP, any_known_key());
      end else begin
        k = random_key(2, 2);
        send_key(OP_INSERT, k);
        remember_key(k);
      end
    end

    // With the table full, new keys wrap all the way round.
    repeat (3) send_key(OP_INSERT, random_key(3, 3));
    repeat (3) send_key(OP_LOOKUP, random_key(4, 4));
    repeat (4) send_key(OP_LOOKUP, any_known_key());
    repeat (2) send_key(OP_INSERT, any_known_key());

    send_item(OP_CLEAR, 8'($urandom), 1'($urandom));
    k = random_key(1, 4);
    send_key(OP_INSERT, k);
    send_key(OP_LOOKUP, k);
    send_item(OP_UNUSED, 8'($urandom), 1'($urandom));
    start = 1'b0;

    while (pending_results != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
